/* sv/crc16_frame_deframer_macros.svh */
// Assertion helpers used by the deframer's frame module (cfd_frame).
`ifndef CRC16_FRAME_DEFRAMER_MACROS_SVH
`define CRC16_FRAME_DEFRAMER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CFD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define CFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/cfd_pkg.sv */
package cfd_pkg;

    localparam int unsigned HDR_BYTES = 5;
    localparam int unsigned CRC_BYTES = 2;
    localparam int unsigned POS_W     = 9;

    localparam logic [POS_W-1:0] POS_MAX           = 9'd511;
    localparam logic [4:0]       PORT_MASK         = 5'h1F;
    localparam logic [7:0]       MAX_PAYLOAD_RESET = 8'd248;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FRAME_ERR = 2'd1,
        STATUS_CRC_ERR   = 2'd2
    } status_t;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic       frame_done;
        status_t    status;
        logic [2:0] dest_address;
        logic [4:0] dest_port;
        logic [2:0] src_address;
        logic [4:0] src_port;
        logic [7:0] delivery_kind;
        logic [7:0] protocol_code;
        logic [7:0] payload_length;
    } result_t;

endpackage

/* sv/cfd_byte_if.sv */
interface cfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       end_of_buffer;

    modport source (output valid, output rx_byte, output end_of_buffer, input ready);
    modport sink (input valid, input rx_byte, input end_of_buffer, output ready);
endinterface

/* sv/cfd_result_if.sv */
interface cfd_result_if;
    logic       valid;
    logic       ready;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       frame_done;
    logic [1:0] status;
    logic [2:0] dest_address;
    logic [4:0] dest_port;
    logic [2:0] src_address;
    logic [4:0] src_port;
    logic [7:0] delivery_kind;
    logic [7:0] protocol_code;
    logic [7:0] payload_length;

    modport source (
        output valid, input ready,
        output payload_valid, output payload_byte, output frame_done, output status,
        output dest_address, output dest_port, output src_address, output src_port,
        output delivery_kind, output protocol_code, output payload_length
    );
    modport sink (
        input valid, output ready,
        input payload_valid, input payload_byte, input frame_done, input status,
        input dest_address, input dest_port, input src_address, input src_port,
        input delivery_kind, input protocol_code, input payload_length
    );
endinterface

/* sv/cfd_crc.sv */
module cfd_crc (
    input  logic [15:0] crc,
    input  logic [7:0]  data,
    output logic [15:0] crc_upd
);
    // Reflected CRC-16/ARC, one byte folded in per call.
    localparam logic [15:0] POLY_REFL = 16'hA001;

    logic [15:0] acc;

    always_comb
    begin
        acc = crc ^ {8'h00, data};
        for (int i = 0; i < 8; i++)
        begin
            if (acc[0])
            begin
                acc = (acc >> 1) ^ POLY_REFL;
            end
            else
            begin
                acc = acc >> 1;
            end
        end
        crc_upd = acc;
    end
endmodule

/* sv/cfd_frame.sv */
`include "crc16_frame_deframer_macros.svh"

module cfd_frame (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [7:0]        rx_byte,
    input  logic              eob,
    input  logic [7:0]        max_payload,
    output logic              has_result,
    output cfd_pkg::result_t  result
);
    import cfd_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [39:0]      hdr_reg, hdr_next;
    logic [15:0]      crc_reg, crc_next;
    logic [15:0]      rxcrc_reg, rxcrc_next;

    logic [15:0]      crc_upd;
    logic [15:0]      crc_acc;
    logic [15:0]      rx_upd;
    logic [39:0]      hdr_upd;
    logic [7:0]       len;
    logic [7:0]       len_f;
    logic [POS_W-1:0] pay_end;
    logic [POS_W-1:0] pos_inc;
    logic [POS_W-1:0] need;
    logic             pvalid;
    status_t          status;

    cfd_crc u_crc (
        .crc     (crc_reg),
        .data    (rx_byte),
        .crc_upd (crc_upd)
    );

    always_comb
    begin
        len     = hdr_reg[39:32];
        pay_end = POS_W'(HDR_BYTES) + {1'b0, len};
        hdr_upd = hdr_reg;
        crc_acc = crc_reg;
        rx_upd  = rxcrc_reg;
        pvalid  = 1'b0;

        if (pos_reg < POS_W'(HDR_BYTES))
        begin
            unique case (pos_reg[2:0])
                3'd0:    hdr_upd[7:0]   = rx_byte;
                3'd1:    hdr_upd[15:8]  = rx_byte;
                3'd2:    hdr_upd[23:16] = rx_byte;
                3'd3:    hdr_upd[31:24] = rx_byte;
                default: hdr_upd[39:32] = rx_byte;
            endcase
            crc_acc = crc_upd;
        end
        else if (pos_reg < pay_end)
        begin
            crc_acc = crc_upd;
            pvalid  = (len <= max_payload);
        end
        else if (pos_reg == pay_end)
        begin
            rx_upd = {rx_byte, rxcrc_reg[7:0]};
        end
        else if (pos_reg == pay_end + POS_W'(1))
        begin
            rx_upd = {rxcrc_reg[15:8], rx_byte};
        end

        pos_inc = (pos_reg == POS_MAX) ? pos_reg : pos_reg + POS_W'(1);

        // Frame error wins over a CRC mismatch.
        len_f = hdr_upd[39:32];
        need  = POS_W'(HDR_BYTES + CRC_BYTES) + {1'b0, len_f};
        if (pos_inc < need || len_f > max_payload)
        begin
            status = STATUS_FRAME_ERR;
        end
        else if (crc_acc != rx_upd)
        begin
            status = STATUS_CRC_ERR;
        end
        else
        begin
            status = STATUS_OK;
        end

        has_result = pvalid || eob;

        result                = '0;
        result.payload_valid  = pvalid;
        result.payload_byte   = pvalid ? rx_byte : 8'd0;
        if (eob)
        begin
            result.frame_done     = 1'b1;
            result.status         = status;
            result.dest_address   = hdr_upd[7:5];
            result.dest_port      = hdr_upd[4:0] & PORT_MASK;
            result.src_address    = hdr_upd[15:13];
            result.src_port       = hdr_upd[12:8] & PORT_MASK;
            result.delivery_kind  = hdr_upd[23:16];
            result.protocol_code  = hdr_upd[31:24];
            result.payload_length = len_f;
        end

        // Clear the frame state after the last byte.
        if (eob)
        begin
            pos_next   = '0;
            hdr_next   = '0;
            crc_next   = '0;
            rxcrc_next = '0;
        end
        else
        begin
            pos_next   = pos_inc;
            hdr_next   = hdr_upd;
            crc_next   = crc_acc;
            rxcrc_next = rx_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            hdr_reg   <= '0;
            crc_reg   <= '0;
            rxcrc_reg <= '0;
        end
        else if (fire)
        begin
            pos_reg   <= pos_next;
            hdr_reg   <= hdr_next;
            crc_reg   <= crc_next;
            rxcrc_reg <= rxcrc_next;
        end
    end

    `CFD_ASSERT_NEXT(a_clear_after_last, clk, rst_n, fire && eob, pos_reg == '0,
        "frame state not cleared after last byte")
    `CFD_ASSERT_NOW(a_fresh_frame_zero, clk, rst_n, pos_reg == '0,
        hdr_reg == '0 && crc_reg == '0 && rxcrc_reg == '0,
        "frame state dirty at start of frame")
    `CFD_ASSERT_NOW(a_payload_after_hdr, clk, rst_n, fire && result.payload_valid,
        pos_reg >= POS_W'(HDR_BYTES), "payload byte reported inside header")
    `CFD_ASSERT_NOW(a_ok_means_match, clk, rst_n,
        fire && eob && result.status == STATUS_OK, crc_acc == rx_upd,
        "ok status with mismatched CRC")
endmodule

/* sv/cfd_out_stage.sv */
module cfd_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  cfd_pkg::result_t  data,
    output logic              slot_free,
    cfd_result_if.source      result_chan
);
    import cfd_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    assign slot_free = !valid_reg || result_chan.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && slot_free)
        begin
            data_reg <= data;
        end
    end

    assign result_chan.valid          = valid_reg;
    assign result_chan.payload_valid  = data_reg.payload_valid;
    assign result_chan.payload_byte   = data_reg.payload_byte;
    assign result_chan.frame_done     = data_reg.frame_done;
    assign result_chan.status         = data_reg.status;
    assign result_chan.dest_address   = data_reg.dest_address;
    assign result_chan.dest_port      = data_reg.dest_port;
    assign result_chan.src_address    = data_reg.src_address;
    assign result_chan.src_port       = data_reg.src_port;
    assign result_chan.delivery_kind  = data_reg.delivery_kind;
    assign result_chan.protocol_code  = data_reg.protocol_code;
    assign result_chan.payload_length = data_reg.payload_length;
endmodule

/* sv/crc16_frame_deframer.sv */
// Channel       Role    Payload
// byte_chan     sink    rx_byte, end_of_buffer
// result_chan   source  payload and header fields, frame_done, status
// max_payload   config  write enable + 8-bit data, no read-back
//
// One byte per cycle sustained unless a stall on result_chan holds it back:
// input register, one pass of byte-wide CRC and header logic, then the output register.
// Reset clears the frame state and loads max_payload with 248.
// A stall on result_chan holds the output register; bytes that report
// nothing (header and CRC bytes) keep flowing until a reporting byte
// meets a full output register.
module crc16_frame_deframer (
    input  logic        clk,
    input  logic        rst_n,
    cfd_byte_if.sink    byte_chan,
    cfd_result_if.source result_chan,
    input  logic        max_payload_we,
    input  logic [7:0]  max_payload_wdata
);
    import cfd_pkg::*;

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_eob_reg;
    logic [7:0] max_payload_reg;

    logic       has_result;
    logic       slot_free;
    logic       s1_adv;
    result_t    result;

    // Length limit register; write only while the block is idle (not enforced by the block).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end
        else if (max_payload_we)
        begin
            max_payload_reg <= max_payload_wdata;
        end
    end

    // Advance the held item when it reports nothing or the output slot opens.
    assign s1_adv          = s1_valid_reg && (!has_result || slot_free);
    assign byte_chan.ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (byte_chan.ready)
        begin
            s1_valid_reg <= byte_chan.valid;
        end
    end

    // Capture the item on accept; payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (byte_chan.valid && byte_chan.ready)
        begin
            s1_byte_reg <= byte_chan.rx_byte;
            s1_eob_reg  <= byte_chan.end_of_buffer;
        end
    end

    cfd_frame u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (s1_adv),
        .rx_byte     (s1_byte_reg),
        .eob         (s1_eob_reg),
        .max_payload (max_payload_reg),
        .has_result  (has_result),
        .result      (result)
    );

    cfd_out_stage u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (s1_adv && has_result),
        .data        (result),
        .slot_free   (slot_free),
        .result_chan (result_chan)
    );
endmodule

/* sim/tb_crc16_frame_deframer.sv */
`timescale 1ns / 1ps
module tb_crc16_frame_deframer;
    import cfd_pkg::*;

    localparam int unsigned HALF_PERIOD     = 10;
    localparam int unsigned RESET_CYCLES    = 9;
    // Time for the block's input and output registers to empty, with margin on top.
    localparam int unsigned DRAIN_CYCLES    = 8;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned CYCLE_LIMIT     = 400000;
    localparam int unsigned PHASE_BYTES     = 40;

    // Shapes of buffer the stimulus can build.
    typedef enum int {
        FRAME_GOOD,
        FRAME_BAD_CRC,
        FRAME_SHORT,
        FRAME_TRAILING,
        FRAME_NOISE
    } frame_kind_t;

    // Deframer scoreboard: tracks the frame in progress, predicts what each
    // accepted byte produces and checks results in order.
    class frame_scoreboard;
        result_t     expected_q[$];
        logic [8:0]  frame_pos;
        logic [39:0] header_bytes;
        logic [15:0] crc_acc;
        logic [15:0] crc_rcvd;
        logic [7:0]  payload_limit;
        int          fail_count;

        function new();
            payload_limit = MAX_PAYLOAD_RESET;
            fail_count    = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            frame_pos    = '0;
            header_bytes = '0;
            crc_acc      = '0;
            crc_rcvd     = '0;
        endfunction

        // CRC-16/ARC, reflected polynomial, one byte.
        static function logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
            logic [15:0] c;
            int          i;
            c = crc ^ {8'h00, b};
            for (i = 0; i < 8; i++)
                c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
            return c;
        endfunction

        function void set_limit(logic [7:0] v);
            payload_limit = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            logic [8:0] pos;
            logic [7:0] len;
            logic       forward;
            result_t    r;
            pos     = frame_pos;
            len     = header_bytes[39:32];
            forward = 1'b0;
            if (pos < HDR_BYTES)
            begin
                header_bytes[8*pos +: 8] = b;
                crc_acc = crc_step(crc_acc, b);
            end
            else if (pos < HDR_BYTES + len)
            begin
                crc_acc = crc_step(crc_acc, b);
                forward = (len <= payload_limit);
            end
            else if (pos == HDR_BYTES + len)
                crc_rcvd[15:8] = b;
            else if (pos == HDR_BYTES + len + 1)
                crc_rcvd[7:0] = b;
            if (frame_pos != POS_MAX)
                frame_pos++;
            if (!forward && !last)
                return;
            r = '0;
            if (forward)
            begin
                r.payload_valid = 1'b1;
                r.payload_byte  = b;
            end
            if (last)
            begin
                len = header_bytes[39:32];
                r.frame_done = 1'b1;
                if (frame_pos < HDR_BYTES + CRC_BYTES + len || len > payload_limit)
                    r.status = STATUS_FRAME_ERR;
                else if (crc_acc != crc_rcvd)
                    r.status = STATUS_CRC_ERR;
                else
                    r.status = STATUS_OK;
                r.dest_address   = header_bytes[7:5];
                r.dest_port      = header_bytes[4:0] & PORT_MASK;
                r.src_address    = header_bytes[15:13];
                r.src_port       = header_bytes[12:8] & PORT_MASK;
                r.delivery_kind  = header_bytes[23:16];
                r.protocol_code  = header_bytes[31:24];
                r.payload_length = len;
                clear_frame();
            end
            expected_q.insert(expected_q.size(), r);
        endfunction

        task report(string msg);
            fail_count++;
            $display("MISMATCH @%0t: %s", $realtime, msg);
        endtask

        task compare(string field, logic [7:0] got, logic [7:0] want);
            if (got !== want)
                report($sformatf("%s got %0h, expected %0h", field, got, want));
        endtask

        task check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("result %h with nothing expected", got));
                return;
            end
            want = expected_q.pop_front();
            compare("payload_valid", got.payload_valid, want.payload_valid);
            compare("payload_byte", got.payload_byte, want.payload_byte);
            compare("frame_done", got.frame_done, want.frame_done);
            compare("status", got.status, want.status);
            compare("dest_address", got.dest_address, want.dest_address);
            compare("dest_port", got.dest_port, want.dest_port);
            compare("src_address", got.src_address, want.src_address);
            compare("src_port", got.src_port, want.src_port);
            compare("delivery_kind", got.delivery_kind, want.delivery_kind);
            compare("protocol_code", got.protocol_code, want.protocol_code);
            compare("payload_length", got.payload_length, want.payload_length);
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        max_payload_we;
    logic [7:0]  max_payload_wdata;

    cfd_byte_if   byte_chan ();
    cfd_result_if result_chan ();

    frame_scoreboard sb;
    logic [7:0]      frame_buf[$];
    bit              hold_off_req;
    int unsigned     bytes_sent;
    int unsigned     cycle_count;
    result_t         seen;

    always #(HALF_PERIOD) clk = ~clk;

    crc16_frame_deframer dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .byte_chan         (byte_chan),
        .result_chan       (result_chan),
        .max_payload_we    (max_payload_we),
        .max_payload_wdata (max_payload_wdata)
    );

    // Input side monitor: every byte taken by the block goes to the predictor.
    // Values read here are the ones the block saw at this edge.
    always @(posedge clk)
    begin
        if (rst_n && byte_chan.valid && byte_chan.ready)
            sb.note_byte(byte_chan.rx_byte, byte_chan.end_of_buffer);
    end

    // Output side monitor: compare each delivered result against the oldest
    // expectation.
    always @(posedge clk)
    begin
        if (rst_n && result_chan.valid && result_chan.ready)
        begin
            seen = '{payload_valid:  result_chan.payload_valid,
                     payload_byte:   result_chan.payload_byte,
                     frame_done:     result_chan.frame_done,
                     status:         status_t'(result_chan.status),
                     dest_address:   result_chan.dest_address,
                     dest_port:      result_chan.dest_port,
                     src_address:    result_chan.src_address,
                     src_port:       result_chan.src_port,
                     delivery_kind:  result_chan.delivery_kind,
                     protocol_code:  result_chan.protocol_code,
                     payload_length: result_chan.payload_length};
            sb.check_result(seen);
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Result receiver: random ready with stalls of varied length; when asked,
    // hold ready low for a long stretch so the block backs up into its input.
    initial
    begin
        int unsigned stall;
        int unsigned run;
        result_chan.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                result_chan.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else
            begin
                result_chan.ready <= 1'b1;
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 24);
                repeat (run) @(posedge clk);
                stall = gap_len();
                if (stall != 0)
                begin
                    result_chan.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
        end
    end

    // Offer one byte, hold it until taken, then idle for the given gap.
    // A zero gap leaves valid high so the next byte follows back to back.
    task automatic send_byte(input logic [7:0] b, input logic last, input int unsigned gap);
        byte_chan.valid         <= 1'b1;
        byte_chan.rx_byte       <= b;
        byte_chan.end_of_buffer <= last;
        do
            @(posedge clk);
        while (!byte_chan.ready);
        if (gap != 0)
        begin
            byte_chan.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Send the whole buffer, flagging its last byte.
    task automatic send_buffer(input bit burst);
        int i;
        for (i = 0; i < frame_buf.size(); i++)
            send_byte(frame_buf[i], i == frame_buf.size() - 1, burst ? 0 : gap_len());
        bytes_sent += frame_buf.size();
    endtask

    // Build a buffer: header (fill < 0 means random node/type/protocol bytes),
    // random payload, big-endian CRC, then bend it into the requested shape.
    // For short buffers a nonzero cut gives the number of bytes kept.
    task automatic build_frame(input int fill, input logic [7:0] len,
                               input frame_kind_t kind, input int cut);
        logic [15:0] crc;
        int          i;
        int          keep;
        int          idx;
        frame_buf.delete();
        for (i = 0; i < 4; i++)
            frame_buf.insert(frame_buf.size(),
                             fill < 0 ? 8'($urandom_range(0, 255)) : 8'(fill));
        frame_buf.insert(frame_buf.size(), len);
        for (i = 0; i < len; i++)
            frame_buf.insert(frame_buf.size(), 8'($urandom_range(0, 255)));
        crc = '0;
        for (i = 0; i < frame_buf.size(); i++)
            crc = frame_scoreboard::crc_step(crc, frame_buf[i]);
        frame_buf.insert(frame_buf.size(), crc[15:8]);
        frame_buf.insert(frame_buf.size(), crc[7:0]);
        case (kind)
            FRAME_BAD_CRC:
            begin
                // flip one bit in either CRC byte
                idx = frame_buf.size() - 1 - int'($urandom_range(0, 1));
                frame_buf[idx] = frame_buf[idx] ^ (8'h01 << $urandom_range(0, 7));
            end
            FRAME_SHORT:
            begin
                keep = (cut > 0) ? cut : int'($urandom_range(1, frame_buf.size() - 1));
                while (frame_buf.size() > keep)
                    void'(frame_buf.pop_back());
            end
            FRAME_TRAILING:
            begin
                repeat ($urandom_range(1, 6))
                    frame_buf.insert(frame_buf.size(), 8'($urandom_range(0, 255)));
            end
            FRAME_NOISE:
            begin
                frame_buf.delete();
                repeat ($urandom_range(1, 12))
                    frame_buf.insert(frame_buf.size(), 8'($urandom_range(0, 255)));
            end
            default: ;
        endcase
    endtask

    // One random frame: mostly short lengths, some around the current limit.
    task automatic random_frame();
        int          r;
        int          lo;
        int          hi;
        logic [7:0]  len;
        frame_kind_t kind;
        r = $urandom_range(0, 99);
        if (r < 75)
            len = 8'($urandom_range(0, 12));
        else if (r < 92)
        begin
            lo  = (sb.payload_limit > 0) ? int'(sb.payload_limit) - 1 : 0;
            hi  = (sb.payload_limit < 254) ? int'(sb.payload_limit) + 2 : 255;
            len = 8'($urandom_range(lo, hi));
        end
        else
            len = 8'($urandom_range(13, 255));
        r = $urandom_range(0, 99);
        if (r < 55)
            kind = FRAME_GOOD;
        else if (r < 67)
            kind = FRAME_BAD_CRC;
        else if (r < 79)
            kind = FRAME_SHORT;
        else if (r < 89)
            kind = FRAME_TRAILING;
        else
            kind = FRAME_NOISE;
        build_frame(-1, len, kind, 0);
        send_buffer($urandom_range(0, 3) == 0);
    endtask

    // Drop valid and wait until every expected result is in, then let the
    // pipeline empty of bytes that report nothing.
    task automatic wait_idle();
        byte_chan.valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [7:0] v);
        max_payload_we    <= 1'b1;
        max_payload_wdata <= v;
        @(posedge clk);
        max_payload_we    <= 1'b0;
        sb.set_limit(v);
    endtask

    task automatic run_random();
        bytes_sent = 0;
        while (bytes_sent < PHASE_BYTES)
            random_frame();
    endtask

    // Watchdog: a hung handshake or a missing result ends here.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("crc16_frame_deframer regression: fail");
        $finish;
    end

    initial
    begin
        sb = new();
        hold_off_req = 1'b0;
        bytes_sent   = 0;
        rst_n                   <= 1'b0;
        byte_chan.valid         <= 1'b0;
        byte_chan.rx_byte       <= '0;
        byte_chan.end_of_buffer <= 1'b0;
        max_payload_we          <= 1'b0;
        max_payload_wdata       <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames at the reset limit.
        // Empty payload, all-zero header.
        build_frame(0, 8'd0, FRAME_GOOD, 0);
        send_buffer(1'b0);
        // All-ones node, type and protocol bytes.
        build_frame(255, 8'd2, FRAME_GOOD, 0);
        send_buffer(1'b0);
        // Corrupted CRC.
        build_frame(-1, 8'd1, FRAME_BAD_CRC, 0);
        send_buffer(1'b0);
        // Buffer of a single byte.
        build_frame(-1, 8'd4, FRAME_SHORT, 1);
        send_buffer(1'b0);
        // Buffer ending inside the payload.
        build_frame(-1, 8'd6, FRAME_SHORT, 8);
        send_buffer(1'b1);
        // Buffer missing only the low CRC byte.
        build_frame(-1, 8'd3, FRAME_SHORT, 9);
        send_buffer(1'b0);
        // Bytes after the CRC are ignored.
        build_frame(-1, 8'd2, FRAME_TRAILING, 0);
        send_buffer(1'b0);

        // Widest limit; stall the receiver while frames stream in back to
        // back so the block fills and pushes back on its input.
        wait_idle();
        write_limit(8'd255);
        hold_off_req = 1'b1;
        build_frame(-1, 8'd24, FRAME_GOOD, 0);
        send_buffer(1'b1);
        run_random();

        // Zero limit: only empty payloads pass.
        wait_idle();
        write_limit(8'd0);
        run_random();

        wait_idle();
        write_limit(8'd3);
        // Length exactly at the limit.
        build_frame(-1, 8'd3, FRAME_GOOD, 0);
        send_buffer(1'b1);
        // Length over the limit with a bad CRC: frame error must win.
        build_frame(-1, 8'd4, FRAME_BAD_CRC, 0);
        send_buffer(1'b0);
        run_random();

        wait_idle();
        write_limit(8'($urandom_range(1, 254)));
        run_random();

        // Back to the reset value.
        wait_idle();
        write_limit(MAX_PAYLOAD_RESET);
        run_random();

        wait_idle();
        if (sb.fail_count == 0)
            $display("crc16_frame_deframer regression: pass");
        else
            $display("crc16_frame_deframer regression: fail");
        $finish;
    end

endmodule
